// ===== hw/rtl/bse_pkg.sv =====
// Shared types, code tables and character classifier for the Baudot shift encoder.
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

  // Kept teleprinter shift; a value of 3 never arises
  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_LTRS = 2'd1,
    SHIFT_FIGS = 2'd2
  } shift_e;

  localparam int unsigned CodeW    = 5;
  localparam int unsigned CharW    = 8;
  localparam int unsigned NumLtrs  = 26;
  localparam int unsigned NumDigs  = 10;

  localparam logic [CodeW-1:0] CodeLtrs  = 5'd31;
  localparam logic [CodeW-1:0] CodeFigs  = 5'd27;
  localparam logic [CodeW-1:0] CodeSpace = 5'd4;
  localparam logic [CodeW-1:0] CodeCr    = 5'd2;
  localparam logic [CodeW-1:0] CodeLf    = 5'd8;
  localparam logic [CodeW-1:0] CodeNull  = 5'd0;

  localparam logic [CodeW-1:0] LetterCodes [NumLtrs] = '{
    5'd3, 5'd25, 5'd14, 5'd9, 5'd1, 5'd13, 5'd26, 5'd20, 5'd6, 5'd11, 5'd15, 5'd18, 5'd28,
    5'd12, 5'd24, 5'd22, 5'd23, 5'd10, 5'd5, 5'd16, 5'd7, 5'd30, 5'd19, 5'd29, 5'd21, 5'd17
  };

  localparam logic [CodeW-1:0] DigitCodes [NumDigs] = '{
    5'd22, 5'd23, 5'd19, 5'd1, 5'd11, 5'd16, 5'd21, 5'd7, 5'd6, 5'd24
  };

  // Character code and the shift it needs; SHIFT_NONE means shift-neutral
  typedef struct packed {
    shift_e           need;
    logic [CodeW-1:0] code;
  } char_enc_t;

  function automatic char_enc_t encode_char(input logic [CharW-1:0] c);
    char_enc_t res;
    logic      is_letter;
    res.need  = SHIFT_NONE;
    res.code  = CodeNull;
    is_letter = (c[7:6] == 2'b01) && (c[4:0] >= 5'd1) && (c[4:0] <= 5'd26);
    if (c >= 8'h30 && c <= 8'h39) begin
      res.need = SHIFT_FIGS;
      res.code = DigitCodes[c[3:0]];
    end else if (is_letter) begin
      // upper and lower case share the low five bits
      res.need = SHIFT_LTRS;
      res.code = LetterCodes[c[4:0] - 5'd1];
    end else begin
      unique case (c)
        8'h20: res.code = CodeSpace;
        8'h0D: res.code = CodeCr;
        8'h0A: res.code = CodeLf;
        8'h2C: begin res.need = SHIFT_FIGS; res.code = 5'd12; end
        8'h2E: begin res.need = SHIFT_FIGS; res.code = 5'd28; end
        8'h3A: begin res.need = SHIFT_FIGS; res.code = 5'd14; end
        8'h3B: begin res.need = SHIFT_FIGS; res.code = 5'd30; end
        8'h22: begin res.need = SHIFT_FIGS; res.code = 5'd17; end
        8'h21: begin res.need = SHIFT_FIGS; res.code = 5'd13; end
        8'h2F: begin res.need = SHIFT_FIGS; res.code = 5'd29; end
        8'h2D: begin res.need = SHIFT_FIGS; res.code = 5'd3;  end
        8'h27: begin res.need = SHIFT_FIGS; res.code = 5'd10; end
        8'h28: begin res.need = SHIFT_FIGS; res.code = 5'd15; end
        8'h29: begin res.need = SHIFT_FIGS; res.code = 5'd18; end
        8'h26: begin res.need = SHIFT_FIGS; res.code = 5'd26; end
        8'h23: begin res.need = SHIFT_FIGS; res.code = 5'd20; end
        8'h3F: begin res.need = SHIFT_FIGS; res.code = 5'd25; end
        default: res.code = CodeNull;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/baudot_shift_encoder.sv =====
// Baudot shift encoder: ASCII bytes in, five-bit teleprinter codes out.
//
// Input channel: in_valid_i / in_stall_o carry one ASCII byte per request.
// Output channel: out_valid_o / out_stall_i carry one code per request;
// last_code_o is 0 on a shift code that precedes a character and 1 on the
// character's own code. Letters need the letters shift, digits and
// punctuation the figures shift; the shift code goes out only when the
// kept shift differs. Space, CR, LF and NUL keep the shift; other bytes
// give code 0.
// Data path: a byte lands in the input register and is encoded from there
// into the output register once the output slot is free. Throughput is
// one byte per cycle when no shift code is needed and the receiver does
// not stall; when one is, the single output port sends one code per
// cycle while not stalled, the character's code waiting in a holding
// register and the next byte held in the input register meanwhile.
// Reset empties all registers and sets the kept shift to unknown, so the
// first letter or figure is always preceded by its shift code.
// While the receiver stalls, the output code holds and the input stalls
// once the input register is full.
`timescale 1ns / 1ps
`default_nettype none

module baudot_shift_encoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bse_pkg::CharW-1:0]   ascii_char_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [bse_pkg::CodeW-1:0]   baudot_code_o,
  output logic                             last_code_o
);

  logic                        in_vld_q;
  logic [bse_pkg::CharW-1:0]   in_char_q;
  bse_pkg::shift_e             shift_q, shift_d;
  logic                        out_vld_q, out_vld_d;
  logic [bse_pkg::CodeW-1:0]   out_code_q, out_code_d;
  logic                        out_last_q, out_last_d;
  logic                        pend_vld_q, pend_vld_d;
  logic [bse_pkg::CodeW-1:0]   pend_code_q, pend_code_d;

  bse_pkg::char_enc_t          enc;
  logic                        need_shift;
  logic                        out_free;
  logic                        in_take;
  logic                        in_acc;

  // Classify the held byte against the kept shift
  always_comb begin
    enc        = bse_pkg::encode_char(in_char_q);
    need_shift = (enc.need != bse_pkg::SHIFT_NONE) && (enc.need != shift_q);
  end

  // Advance the output slot: drain a pending code first, then a new byte
  always_comb begin
    out_free    = !out_vld_q || !out_stall_i;
    in_take     = out_free && !pend_vld_q && in_vld_q;
    in_acc      = in_valid_i && !in_stall_o;
    out_vld_d   = out_vld_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;
    pend_vld_d  = pend_vld_q;
    pend_code_d = pend_code_q;
    shift_d     = shift_q;
    if (out_free) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_code_d = pend_code_q;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
      end else if (in_vld_q) begin
        out_vld_d = 1'b1;
        if (need_shift) begin
          out_code_d  = (enc.need == bse_pkg::SHIFT_LTRS) ? bse_pkg::CodeLtrs
                                                          : bse_pkg::CodeFigs;
          out_last_d  = 1'b0;
          pend_vld_d  = 1'b1;
          pend_code_d = enc.code;
          shift_d     = enc.need;
        end else begin
          out_code_d = enc.code;
          out_last_d = 1'b1;
        end
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  assign in_stall_o    = in_vld_q && !in_take;
  assign out_valid_o   = out_vld_q;
  assign baudot_code_o = out_code_q;
  assign last_code_o   = out_last_q;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      shift_q    <= bse_pkg::SHIFT_NONE;
    end else begin
      in_vld_q   <= in_acc || (in_vld_q && !in_take);
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
      shift_q    <= shift_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_char_q <= ascii_char_i;
    end
    out_code_q  <= out_code_d;
    out_last_q  <= out_last_d;
    pend_code_q <= pend_code_d;
  end

endmodule

`default_nettype wire
